>>> sv/clarke_park_transform_top_assert.svh
// assertion macros used by the clarke/park transform checker
`ifndef CLARKE_PARK_TRANSFORM_TOP_ASSERT_SVH
`define CLARKE_PARK_TRANSFORM_TOP_ASSERT_SVH

// same-cycle implication, disabled while rst is high
`define CPT_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("clarke park transform: property failed");

// next-cycle implication, disabled while rst is high
`define CPT_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("clarke park transform: property failed");

`endif

>>> sv/cpt_pkg.sv
// types, constants and arithmetic helpers for the clarke/park transform
package cpt_pkg;

   localparam int FRAC_BITS  = 5;
   localparam int DATA_WIDTH = 32;
   localparam int WORD_W     = 32;
   localparam int TRIG_W     = 17;
   localparam int PROD_W     = WORD_W + TRIG_W;
   localparam int SUM_W      = PROD_W + 1;
   localparam int LANES      = 4;

   typedef logic signed [WORD_W-1:0] word_type;
   typedef logic signed [TRIG_W-1:0] trig_type;
   typedef logic signed [PROD_W-1:0] prod_type;
   typedef logic signed [SUM_W-1:0]  sum_type;

   typedef enum logic {
      CMD_FWD = 1'b0,
      CMD_INV = 1'b1
   } cmd_type;

   // sideband carried alongside the products
   typedef struct packed {
      cmd_type  cmd;
      word_type alpha;
      word_type beta;
      trig_type cos_v;
      trig_type sin_v;
   } side_type;

   // sqrt3 in q30, scaled down to FRAC_BITS
   localparam longint SQRT3_Q30  = 64'sd1859775393;
   localparam longint K_SQRT3_L  = SQRT3_Q30 >>> (30 - FRAC_BITS);
   localparam longint K_INV_L    = (64'sd1 <<< (2 * FRAC_BITS)) / K_SQRT3_L;
   localparam longint K_TWO_INV_L = (64'sd2 <<< (2 * FRAC_BITS)) / K_SQRT3_L;
   localparam longint K_HALF_L   = (K_SQRT3_L <<< FRAC_BITS) / (64'sd2 <<< FRAC_BITS);

   localparam trig_type K_INV_SQRT3     = trig_type'(K_INV_L);
   localparam trig_type K_TWO_INV_SQRT3 = trig_type'(K_TWO_INV_L);
   localparam trig_type K_SQRT3_HALF    = trig_type'(K_HALF_L);

   localparam sum_type SAT_HI = sum_type'((64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1);
   localparam sum_type SAT_LO = sum_type'(-(64'sd1 <<< (DATA_WIDTH - 1)));

   // floor scaling of a full product, widened for summing
   function automatic sum_type shr(input prod_type p);
      prod_type q;
      q = p >>> FRAC_BITS;
      return sum_type'(q);
   endfunction

   // clamp to the data range, sign extended to the port width
   function automatic word_type sat_word(input sum_type v);
      sum_type c;
      if (v > SAT_HI) begin
         c = SAT_HI;
      end else if (v < SAT_LO) begin
         c = SAT_LO;
      end else begin
         c = v;
      end
      return word_type'(c[WORD_W-1:0]);
   endfunction

endpackage

>>> sv/cpt_mul_stage.sv
// four-lane signed multiplier stage with registered products and sideband
module cpt_mul_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  logic                 valid_in,
   input  cpt_pkg::word_type    op_a [cpt_pkg::LANES],
   input  cpt_pkg::trig_type    op_b [cpt_pkg::LANES],
   input  cpt_pkg::side_type    side_in,
   output logic                 valid_out,
   output cpt_pkg::prod_type    prod_out [cpt_pkg::LANES],
   output cpt_pkg::side_type    side_out
);

   logic              valid_ff;
   cpt_pkg::prod_type prod_ff [cpt_pkg::LANES];
   cpt_pkg::prod_type prod_in [cpt_pkg::LANES];
   cpt_pkg::side_type side_ff;

   always_comb begin
      for (int i = 0; i < cpt_pkg::LANES; i++) begin
         prod_in[i] = cpt_pkg::prod_type'(op_a[i]) * cpt_pkg::prod_type'(op_b[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         prod_ff <= prod_in;
         side_ff <= side_in;
      end
   end

   assign valid_out = valid_ff;
   assign prod_out  = prod_ff;
   assign side_out  = side_ff;

endmodule

>>> sv/cpt_mix_stage.sv
// forms alpha and beta from the first product stage
module cpt_mix_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  logic                 valid_in,
   input  cpt_pkg::prod_type    prod_in [cpt_pkg::LANES],
   input  cpt_pkg::side_type    side_in,
   output logic                 valid_out,
   output cpt_pkg::side_type    side_out
);

   logic              valid_ff;
   cpt_pkg::side_type side_ff;
   cpt_pkg::side_type side_in_next;

   always_comb begin
      side_in_next = side_in;
      unique case (side_in.cmd)
         cpt_pkg::CMD_FWD: begin
            // clarke: alpha is phase a unchanged, beta = a/sqrt3 + 2b/sqrt3
            side_in_next.beta = cpt_pkg::sat_word(cpt_pkg::shr(prod_in[0])
                                                + cpt_pkg::shr(prod_in[1]));
         end
         cpt_pkg::CMD_INV: begin
            // inverse park
            side_in_next.alpha = cpt_pkg::sat_word(cpt_pkg::shr(prod_in[0])
                                                 - cpt_pkg::shr(prod_in[1]));
            side_in_next.beta  = cpt_pkg::sat_word(cpt_pkg::shr(prod_in[2])
                                                 + cpt_pkg::shr(prod_in[3]));
         end
         default: begin
            side_in_next = side_in;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         side_ff <= side_in_next;
      end
   end

   assign valid_out = valid_ff;
   assign side_out  = side_ff;

endmodule

>>> sv/cpt_out_stage.sv
// final sums and saturation into the result register
module cpt_out_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  logic                 valid_in,
   input  cpt_pkg::prod_type    prod_in [cpt_pkg::LANES],
   input  cpt_pkg::side_type    side_in,
   output logic                 valid_out,
   output cpt_pkg::word_type    out_x,
   output cpt_pkg::word_type    out_y,
   output cpt_pkg::word_type    out_z
);

   logic              valid_ff;
   cpt_pkg::word_type x_ff;
   cpt_pkg::word_type y_ff;
   cpt_pkg::word_type z_ff;
   cpt_pkg::word_type x_in;
   cpt_pkg::word_type y_in;
   cpt_pkg::word_type z_in;
   cpt_pkg::word_type half;
   cpt_pkg::sum_type  r1;
   cpt_pkg::sum_type  r2;

   always_comb begin
      // halving toward zero: bias negatives by one before the shift
      half = (side_in.alpha + cpt_pkg::word_type'({1'b0, side_in.alpha[cpt_pkg::WORD_W-1]}))
             >>> 1;
      r1   = -cpt_pkg::sum_type'(half);
      r2   = cpt_pkg::shr(prod_in[0]);
      unique case (side_in.cmd)
         cpt_pkg::CMD_FWD: begin
            x_in = cpt_pkg::sat_word(cpt_pkg::shr(prod_in[0]) + cpt_pkg::shr(prod_in[1]));
            y_in = cpt_pkg::sat_word(cpt_pkg::shr(prod_in[3]) - cpt_pkg::shr(prod_in[2]));
            z_in = '0;
         end
         cpt_pkg::CMD_INV: begin
            x_in = side_in.alpha;
            y_in = cpt_pkg::sat_word(r1 + r2);
            z_in = cpt_pkg::sat_word(r1 - r2);
         end
         default: begin
            x_in = '0;
            y_in = '0;
            z_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         x_ff <= x_in;
         y_ff <= y_in;
         z_ff <= z_in;
      end
   end

   assign valid_out = valid_ff;
   assign out_x     = x_ff;
   assign out_y     = y_ff;
   assign out_z     = z_ff;

endmodule

>>> sv/clarke_park_transform_top.sv
// top level of the fixed-point clarke/park transform pipeline
//
// fixed-point field-oriented-control transform. each request transfer carries
// a direction (forward: phase a, b to d, q; inverse: d, q to phase a, b, c),
// two values and the rotor angle's cosine and sine with cpt_pkg::FRAC_BITS
// fraction bits. the unit accepts one transfer per clock while req_stall is low
// and returns one response transfer per request, in order. the four stages
// are: a four-lane multiply, an add/saturate forming alpha and beta, a second
// four-lane multiply, and an add/saturate into the response register. every
// stage holds its own valid bit and advances when the stage after it has room,
// so bubbles are squeezed out and a stalled response does not block requests
// until the pipe is full. products are floor-scaled by FRAC_BITS, sums clamp
// to cpt_pkg::DATA_WIDTH signed bits, rsp_out_z is zero for forward transfers.
module clarke_park_transform_top (
   input  logic                 clock,
   input  logic                 reset,
   // request channel
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_cmd,
   input  cpt_pkg::word_type    req_value_x,
   input  cpt_pkg::word_type    req_value_y,
   input  cpt_pkg::trig_type    req_cos_value,
   input  cpt_pkg::trig_type    req_sin_value,
   // response channel
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output cpt_pkg::word_type    rsp_out_x,
   output cpt_pkg::word_type    rsp_out_y,
   output cpt_pkg::word_type    rsp_out_z
);

   // per-stage valid and load enables
   logic              s1_valid;
   logic              s2_valid;
   logic              s3_valid;
   logic              s1_load;
   logic              s2_load;
   logic              s3_load;
   logic              s4_load;

   // stage 1 operands and outputs
   cpt_pkg::word_type a1_op [cpt_pkg::LANES];
   cpt_pkg::trig_type b1_op [cpt_pkg::LANES];
   cpt_pkg::side_type s0_side;
   cpt_pkg::prod_type s1_prod [cpt_pkg::LANES];
   cpt_pkg::side_type s1_side;

   // stage 2 result (alpha, beta)
   cpt_pkg::side_type s2_side;

   // stage 3 operands and outputs
   cpt_pkg::word_type a3_op [cpt_pkg::LANES];
   cpt_pkg::trig_type b3_op [cpt_pkg::LANES];
   cpt_pkg::prod_type s3_prod [cpt_pkg::LANES];
   cpt_pkg::side_type s3_side;

   // a stage loads when it is empty or the stage after it moves on;
   // the response register is the end of the chain
   assign s4_load   = !rsp_valid || !rsp_stall;
   assign s3_load   = !s3_valid || s4_load;
   assign s2_load   = !s2_valid || s3_load;
   assign s1_load   = !s1_valid || s2_load;
   assign req_stall = !s1_load;

   // sideband: the request's direction, phase a as forward alpha, angle terms
   always_comb begin
      s0_side.cmd   = cpt_pkg::cmd_type'(req_cmd);
      s0_side.alpha = req_value_x;
      s0_side.beta  = req_value_y;
      s0_side.cos_v = req_cos_value;
      s0_side.sin_v = req_sin_value;
   end

   // first multiply: clarke scaling (forward) or the four park products (inverse)
   always_comb begin
      a1_op[0] = req_value_x;
      a1_op[1] = req_value_y;
      a1_op[2] = req_value_x;
      a1_op[3] = req_value_y;
      b1_op[2] = req_sin_value;
      b1_op[3] = req_cos_value;
      unique case (cpt_pkg::cmd_type'(req_cmd))
         cpt_pkg::CMD_FWD: begin
            b1_op[0] = cpt_pkg::K_INV_SQRT3;
            b1_op[1] = cpt_pkg::K_TWO_INV_SQRT3;
         end
         cpt_pkg::CMD_INV: begin
            b1_op[0] = req_cos_value;
            b1_op[1] = req_sin_value;
         end
         default: begin
            b1_op[0] = req_cos_value;
            b1_op[1] = req_sin_value;
         end
      endcase
   end

   cpt_mul_stage u_mul_a (
      .clock     (clock),
      .reset     (reset),
      .load      (s1_load),
      .valid_in  (req_valid),
      .op_a      (a1_op),
      .op_b      (b1_op),
      .side_in   (s0_side),
      .valid_out (s1_valid),
      .prod_out  (s1_prod),
      .side_out  (s1_side)
   );

   cpt_mix_stage u_mix (
      .clock     (clock),
      .reset     (reset),
      .load      (s2_load),
      .valid_in  (s1_valid),
      .prod_in   (s1_prod),
      .side_in   (s1_side),
      .valid_out (s2_valid),
      .side_out  (s2_side)
   );

   // second multiply: park products (forward) or beta * sqrt3/2 (inverse)
   always_comb begin
      a3_op[1] = s2_side.beta;
      a3_op[2] = s2_side.alpha;
      a3_op[3] = s2_side.beta;
      b3_op[1] = s2_side.sin_v;
      b3_op[2] = s2_side.sin_v;
      b3_op[3] = s2_side.cos_v;
      unique case (s2_side.cmd)
         cpt_pkg::CMD_FWD: begin
            a3_op[0] = s2_side.alpha;
            b3_op[0] = s2_side.cos_v;
         end
         cpt_pkg::CMD_INV: begin
            a3_op[0] = s2_side.beta;
            b3_op[0] = cpt_pkg::K_SQRT3_HALF;
         end
         default: begin
            a3_op[0] = s2_side.alpha;
            b3_op[0] = s2_side.cos_v;
         end
      endcase
   end

   cpt_mul_stage u_mul_b (
      .clock     (clock),
      .reset     (reset),
      .load      (s3_load),
      .valid_in  (s2_valid),
      .op_a      (a3_op),
      .op_b      (b3_op),
      .side_in   (s2_side),
      .valid_out (s3_valid),
      .prod_out  (s3_prod),
      .side_out  (s3_side)
   );

   // final sums land in the response register
   cpt_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (s4_load),
      .valid_in  (s3_valid),
      .prod_in   (s3_prod),
      .side_in   (s3_side),
      .valid_out (rsp_valid),
      .out_x     (rsp_out_x),
      .out_y     (rsp_out_y),
      .out_z     (rsp_out_z)
   );

endmodule

>>> sv/cpt_checker.sv
// port-level checker for the clarke/park transform, bound to the top level
`include "clarke_park_transform_top_assert.svh"

module cpt_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input cpt_pkg::word_type rsp_out_x,
   input cpt_pkg::word_type rsp_out_y,
   input cpt_pkg::word_type rsp_out_z
);

   // the pipe is empty after reset
   `CPT_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid)

   // a held response keeps its payload
   `CPT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_out_x) && $stable(rsp_out_y) && $stable(rsp_out_z))

   // requests are only held off when a response is waiting
   `CPT_ASSERT_IMPL(a_stall_cause, clock, reset, req_stall, rsp_valid && rsp_stall)

   // with the response side not stalling, an accepted transfer reaches the response register
   `CPT_ASSERT_NEXT(a_latency, clock, reset, (req_valid && !req_stall) ##1 !rsp_stall ##1 !rsp_stall ##1 !rsp_stall, rsp_valid)

endmodule

bind clarke_park_transform_top cpt_checker u_cpt_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_out_x (rsp_out_x),
   .rsp_out_y (rsp_out_y),
   .rsp_out_z (rsp_out_z)
);

>>> sim/tb.sv
// self-checking testbench for the clarke/park transform pipeline
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   typedef cpt_pkg::word_type word_type;
   typedef cpt_pkg::trig_type trig_type;
   typedef cpt_pkg::cmd_type  cmd_type;

   // scaling of the fixed-point arithmetic
   localparam int     FB        = cpt_pkg::FRAC_BITS;
   localparam longint ROOT3_Q30 = 64'sd1859775393;
   localparam longint ROOT3_FX  = ROOT3_Q30 >>> (30 - FB);
   // derived factors, truncating division as the datapath does
   localparam longint INV_ROOT3     = (64'sd1 <<< (2 * FB)) / ROOT3_FX;
   localparam longint TWO_INV_ROOT3 = (64'sd2 <<< (2 * FB)) / ROOT3_FX;
   localparam longint HALF_ROOT3    = (ROOT3_FX <<< FB) / (64'sd2 <<< FB);
   // saturation bounds of every sum
   localparam longint WORD_MAX = (64'sd1 <<< (cpt_pkg::DATA_WIDTH - 1)) - 64'sd1;
   localparam longint WORD_MIN = -WORD_MAX - 64'sd1;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int REPORT_LIMIT = 10;
   localparam int SETTLE_CYCLES = 12;

   // one response transfer as the transform should produce it
   typedef struct {
      cmd_type  cmd;
      word_type out_x;
      word_type out_y;
      word_type out_z;
   } phase_result_type;

   // clock and reset, every input known from time zero
   logic     clock         = 1'b0;
   logic     reset         = 1'b1;
   logic     req_valid     = 1'b0;
   logic     req_stall;
   logic     req_cmd       = 1'b0;
   word_type req_value_x   = '0;
   word_type req_value_y   = '0;
   trig_type req_cos_value = '0;
   trig_type req_sin_value = '0;
   logic     rsp_valid;
   logic     rsp_stall     = 1'b0;
   word_type rsp_out_x;
   word_type rsp_out_y;
   word_type rsp_out_z;

   // idle percentages for the current phase
   int unsigned send_idle_pct = 0;
   int unsigned rsp_stall_pct = 0;

   // results still owed by the pipeline, oldest first
   phase_result_type awaited_results[$];
   int unsigned      fault_count = 0;
   int unsigned      cycle_count = 0;

   clarke_park_transform_top dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_cmd       (req_cmd),
      .req_value_x   (req_value_x),
      .req_value_y   (req_value_y),
      .req_cos_value (req_cos_value),
      .req_sin_value (req_sin_value),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_x     (rsp_out_x),
      .rsp_out_y     (rsp_out_y),
      .rsp_out_z     (rsp_out_z)
   );

   always #1 clock = ~clock;

   // full product scaled down by the fraction bits, floor rounding
   function automatic longint scale_mul(input longint a, input longint b);
      longint p;
      p = a * b;
      return p >>> FB;
   endfunction

   function automatic longint clamp_word(input longint v);
      if (v > WORD_MAX) begin
         return WORD_MAX;
      end else if (v < WORD_MIN) begin
         return WORD_MIN;
      end
      return v;
   endfunction

   // expected d/q (forward) or phases a/b/c (inverse) for one request
   function automatic phase_result_type transform_phases(input cmd_type cmd,
         input word_type x, input word_type y, input trig_type c, input trig_type s);
      phase_result_type r;
      longint alpha, beta, d_val, q_val, neg_half, rot;
      r.cmd = cmd;
      if (cmd == cpt_pkg::CMD_FWD) begin
         // clarke with a+b+c=0, then park; alpha is phase a untouched
         alpha = x;
         beta  = clamp_word(scale_mul(x, INV_ROOT3) + scale_mul(y, TWO_INV_ROOT3));
         d_val = clamp_word(scale_mul(alpha, c) + scale_mul(beta, s));
         q_val = clamp_word(-scale_mul(alpha, s) + scale_mul(beta, c));
         r.out_x = word_type'(d_val);
         r.out_y = word_type'(q_val);
         r.out_z = '0;
      end else begin
         // inverse park, then inverse clarke; halving truncates toward zero
         alpha    = clamp_word(scale_mul(x, c) - scale_mul(y, s));
         beta     = clamp_word(scale_mul(x, s) + scale_mul(y, c));
         neg_half = -(alpha / 2);
         rot      = scale_mul(beta, HALF_ROOT3);
         r.out_x  = word_type'(alpha);
         r.out_y  = word_type'(clamp_word(neg_half + rot));
         r.out_z  = word_type'(clamp_word(neg_half - rot));
      end
      return r;
   endfunction

   // one request transfer, with a random gap in front of it
   task automatic send_item(input cmd_type cmd, input word_type x, input word_type y,
         input trig_type c, input trig_type s);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid     <= 1'b1;
      req_cmd       <= cmd;
      req_value_x   <= x;
      req_value_y   <= y;
      req_cos_value <= c;
      req_sin_value <= s;
      do @(posedge clock); while (req_stall);
      awaited_results.push_back(transform_phases(cmd, x, y, c, s));
   endtask

   // hold the request side quiet until every owed result has come back
   task automatic drain_pipeline();
      req_valid <= 1'b0;
      while (awaited_results.size() != 0) @(posedge clock);
   endtask

   // mostly moderate magnitudes, with full-range and near-rail values mixed in
   function automatic word_type pick_word();
      case ($urandom_range(9))
         0, 1, 2, 3: return word_type'(int'($urandom_range(200000)) - 100000);
         4, 5, 6:    return word_type'($urandom);
         7:          return word_type'(WORD_MAX - longint'($urandom_range(64)));
         8:          return word_type'(WORD_MIN + longint'($urandom_range(64)));
         default:    return word_type'(int'($urandom_range(16)) - 8);
      endcase
   endfunction

   // values within plus or minus one unit half of the time, large and any 17-bit patterns otherwise
   function automatic trig_type pick_trig();
      case ($urandom_range(9))
         0, 1, 2, 3: return trig_type'(int'($urandom_range(64)) - 32);
         4, 5, 6:    return trig_type'(int'($urandom_range(65536)) - 32768);
         7:          return trig_type'($urandom);
         8: begin
            case ($urandom_range(3))
               0:       return trig_type'(32768);
               1:       return trig_type'(-32768);
               2:       return trig_type'(65535);
               default: return trig_type'(-65536);
            endcase
         end
         default: return trig_type'(($urandom_range(1) != 0) ? 32 : -32);
      endcase
   endfunction

   task automatic random_burst(input int unsigned count);
      repeat (count) begin
         send_item(cmd_type'($urandom_range(1)), pick_word(), pick_word(),
                   pick_trig(), pick_trig());
      end
   endtask

   // rails, saturation, identity angles, halving and floor rounding
   task automatic test_corner_values();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      send_item(cpt_pkg::CMD_FWD, 0, 0, 32, 0);
      send_item(cpt_pkg::CMD_INV, 0, 0, 32, 0);
      send_item(cpt_pkg::CMD_FWD, 32'sh7fffffff, 32'sh7fffffff, 32768, 32768);
      send_item(cpt_pkg::CMD_INV, 32'sh7fffffff, 32'sh7fffffff, 32768, -32768);
      send_item(cpt_pkg::CMD_FWD, word_type'(32'h80000000), word_type'(32'h80000000),
                -65536, -65536);
      send_item(cpt_pkg::CMD_INV, word_type'(32'h80000000), word_type'(32'h80000000),
                -65536, 65535);
      send_item(cpt_pkg::CMD_FWD, 32'sh7fffffff, word_type'(32'h80000000), 65535, -65536);
      send_item(cpt_pkg::CMD_INV, word_type'(32'h80000000), 32'sh7fffffff, -32768, 32768);
      // odd negative alpha: halving must round toward zero
      send_item(cpt_pkg::CMD_INV, -3, 0, 32, 0);
      send_item(cpt_pkg::CMD_INV, 3, 0, 32, 0);
      send_item(cpt_pkg::CMD_INV, -1, 0, 1, 0);
      // tiny negative products: floor takes them to minus one
      send_item(cpt_pkg::CMD_FWD, -1, -1, 1, 1);
      send_item(cpt_pkg::CMD_FWD, 1, 1, -1, -1);
      send_item(cpt_pkg::CMD_FWD, 100, 200, 32, 0);
      send_item(cpt_pkg::CMD_FWD, -1000, 500, 0, 32);
      send_item(cpt_pkg::CMD_INV, 1000, -500, 0, -32);
      send_item(cpt_pkg::CMD_INV, word_type'(32'h80000000), word_type'(32'h80000000),
                -32768, -32768);
      send_item(cpt_pkg::CMD_INV, 123456, -654321, 28, -16);
      send_item(cpt_pkg::CMD_FWD, -77777, 31415, -65536, 65535);
   endtask

   task automatic test_back_to_back();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      random_burst(400);
   endtask

   task automatic test_sender_gaps();
      send_idle_pct = 63;
      rsp_stall_pct = 0;
      random_burst(400);
   endtask

   task automatic test_receiver_stalls();
      send_idle_pct = 0;
      rsp_stall_pct = 63;
      random_burst(400);
   endtask

   task automatic test_mixed_gaps();
      send_idle_pct = 17;
      rsp_stall_pct = 17;
      random_burst(450);
   endtask

   // response side backpressure, redrawn every cycle
   always @(posedge clock) begin
      rsp_stall <= (rsp_stall_pct != 0) && ($urandom_range(99) < rsp_stall_pct);
   end

   task automatic check_field(input string field, input cmd_type cmd,
         input word_type want, input word_type got);
      if (got !== want) begin
         fault_count++;
         if (fault_count <= REPORT_LIMIT) begin
            $display("mismatch on %s (cmd %0d): expected %0d, got %0d",
                     field, cmd, want, got);
         end
      end
   endtask

   // every response transfer is held against the oldest owed result
   always @(posedge clock) begin
      phase_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_results.size() == 0) begin
            fault_count++;
            if (fault_count <= REPORT_LIMIT) begin
               $display("response transfer with nothing owed: x %0d y %0d z %0d",
                        rsp_out_x, rsp_out_y, rsp_out_z);
            end
         end else begin
            want = awaited_results.pop_front();
            check_field("out_x", want.cmd, want.out_x, rsp_out_x);
            check_field("out_y", want.cmd, want.out_y, rsp_out_y);
            check_field("out_z", want.cmd, want.out_z, rsp_out_z);
         end
      end
   end

   // watchdog against a hung handshake
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_corner_values();
      // full stop: nothing goes in until the pipe has emptied
      drain_pipeline();
      test_back_to_back();
      test_sender_gaps();
      drain_pipeline();
      test_receiver_stalls();
      test_mixed_gaps();

      // let the last transfers out, then a short settle for strays
      drain_pipeline();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fault_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
